/* rtl/slpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpd_pkg: shared types and constants of the sync/length packet deframer
// Item types of both channels, register indexes and frame layout constants.
// ----------------------------------------------------------------------------
package slpd_pkg;

  // frame layout
  localparam int unsigned SLPD_MAX_FRAME_DEFAULT = 128;
  localparam int unsigned POS_SYNC2              = 1;
  localparam int unsigned POS_ID                 = 2;
  localparam int unsigned POS_LEN                = 3;
  localparam int unsigned POS_PAYLOAD            = 4;
  localparam int unsigned STORE_BYTES            = 28;
  localparam int unsigned STORE_WORDS            = STORE_BYTES / 4;
  localparam int unsigned HEADER_CRC_BYTES       = 6;
  // wide enough for the frame total (6 + 255) and any position up to 256
  localparam int unsigned CMP_W                  = 9;
  localparam int unsigned STORE_IDX_W            = $clog2(STORE_BYTES);

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FIRST_SYNC  = 2'd0,
    CFG_SECOND_SYNC = 2'd1,
    CFG_ATTITUDE_ID = 2'd2
  } cfg_reg_e;

  localparam logic [7:0] FIRST_SYNC_RESET  = 8'hAA;
  localparam logic [7:0] SECOND_SYNC_RESET = 8'h55;
  localparam logic [7:0] ATTITUDE_ID_RESET = 8'h01;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [7:0]  message_id;
    logic [7:0]  payload_length;
    logic [31:0] packet_count;
    logic        is_attitude;
    logic [31:0] quat_w_bits;
    logic [31:0] quat_x_bits;
    logic [31:0] quat_y_bits;
    logic [31:0] quat_z_bits;
    logic [31:0] roll_bits;
    logic [31:0] pitch_bits;
    logic [31:0] yaw_bits;
  } result_t;

endpackage

/* rtl/slpd_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpd_stream_if: valid/ready channel
// Carries one item per accepted handshake; payload type set per instance.
// ----------------------------------------------------------------------------
interface slpd_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/sync_length_packet_deframer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_packet_deframer_core: sync word / length prefixed deframer
// Hunts for two sync bytes, takes id and length, counts payload and CRC bytes
// and emits one result per completed frame.
// ----------------------------------------------------------------------------
// usage
//   rx     : sink channel, one received serial byte per item
//   result : source channel, one item per completed frame (id, length,
//            packet count, attitude flag and seven raw words from payload
//            bytes 0..27, stale bytes kept on short frames)
//   cfg    : write port, cfg_index 0 first sync, 1 second sync, 2 attitude id;
//            other indexes are ignored; write only while the block is idle
// timing
//   every byte is handled in the cycle it is accepted, so one byte per cycle
//   is taken while rx.ready is high; the result of the frame's last byte is
//   registered into the result buffer as that byte is accepted
//   rx.ready is low only while both entries of the two-deep result buffer
//   are full, i.e. after the receiver has stalled across two results
// reset
//   rst clears the framer to the hunt, the packet counter and the payload
//   byte store to zero, the registers to 0xAA, 0x55 and 0x01
// ----------------------------------------------------------------------------
module sync_length_packet_deframer_core
  import slpd_pkg::*;
#(
  parameter int unsigned MAX_FRAME = SLPD_MAX_FRAME_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  slpd_stream_if.sink   rx,
  slpd_stream_if.source result
);

  localparam int unsigned POS_W = $clog2(MAX_FRAME);

  // configuration registers
  logic [7:0] first_sync;
  logic [7:0] second_sync;
  logic [7:0] attitude_id;

  // framer state
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [7:0]       held_id;
  logic [7:0]       held_id_next;
  logic [7:0]       held_len;
  logic [7:0]       held_len_next;
  logic [31:0]      pkt_count;
  logic [31:0]      pkt_count_next;
  logic [7:0]       store      [STORE_BYTES];
  logic [7:0]       store_next [STORE_BYTES];

  logic             accept;
  logic             buf_ready;
  logic             push;
  logic [7:0]       b;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] inc_w;
  logic [CMP_W-1:0] total_w;
  logic [CMP_W-1:0] store_off;
  logic             in_store;
  logic [STORE_IDX_W-1:0] store_idx;
  logic [31:0]      words [STORE_WORDS];
  result_t          res;

  assign rx.ready = buf_ready;
  assign accept   = rx.valid && buf_ready;
  assign b        = rx.payload.rx_byte;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= FIRST_SYNC_RESET;
      second_sync <= SECOND_SYNC_RESET;
      attitude_id <= ATTITUDE_ID_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_FIRST_SYNC:  first_sync  <= cfg_data;
        CFG_SECOND_SYNC: second_sync <= cfg_data;
        CFG_ATTITUDE_ID: attitude_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // position arithmetic in a common compare width
  assign pos_w     = CMP_W'(pos);
  assign inc_w     = pos_w + CMP_W'(1);
  assign total_w   = CMP_W'(HEADER_CRC_BYTES) + CMP_W'(held_len_next);
  assign store_off = pos_w - CMP_W'(POS_PAYLOAD);
  assign in_store  = (pos_w >= CMP_W'(POS_PAYLOAD)) &&
                     (pos_w < CMP_W'(POS_PAYLOAD + STORE_BYTES));
  assign store_idx = store_off[STORE_IDX_W-1:0];

  always_comb begin
    pos_next       = pos;
    held_id_next   = held_id;
    held_len_next  = held_len;
    pkt_count_next = pkt_count;
    push           = 1'b0;
    for (int k = 0; k < STORE_BYTES; k++) begin
      store_next[k] = store[k];
    end

    if (accept) begin
      if (pos == '0) begin
        // hunting for the first sync byte
        if (b == first_sync) begin
          pos_next = POS_W'(1);
        end
      end else if (pos_w == CMP_W'(POS_SYNC2)) begin
        // a mismatch goes back to the hunt without a retest of this byte
        pos_next = (b == second_sync) ? POS_W'(2) : '0;
      end else begin
        if (pos_w == CMP_W'(POS_ID)) begin
          held_id_next = b;
        end
        if (pos_w == CMP_W'(POS_LEN)) begin
          held_len_next = b;
        end
        for (int k = 0; k < STORE_BYTES; k++) begin
          if (in_store && (store_idx == STORE_IDX_W'(k))) begin
            store_next[k] = b;
          end
        end

        if (inc_w >= CMP_W'(POS_PAYLOAD) && inc_w >= total_w) begin
          // frame complete, crc not checked
          pos_next       = '0;
          pkt_count_next = pkt_count + 32'd1;
          push           = 1'b1;
        end else if (inc_w >= CMP_W'(MAX_FRAME)) begin
          // oversize frame dropped silently
          pos_next = '0;
        end else begin
          pos_next = POS_W'(inc_w);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      held_id   <= '0;
      held_len  <= '0;
      pkt_count <= '0;
      for (int k = 0; k < STORE_BYTES; k++) begin
        store[k] <= '0;
      end
    end else begin
      pos       <= pos_next;
      held_id   <= held_id_next;
      held_len  <= held_len_next;
      pkt_count <= pkt_count_next;
      for (int k = 0; k < STORE_BYTES; k++) begin
        store[k] <= store_next[k];
      end
    end
  end

  // little-endian words from the updated byte store
  always_comb begin
    for (int w = 0; w < STORE_WORDS; w++) begin
      words[w] = {store_next[4*w+3], store_next[4*w+2],
                  store_next[4*w+1], store_next[4*w]};
    end
  end

  always_comb begin
    res.message_id     = held_id_next;
    res.payload_length = held_len_next;
    res.packet_count   = pkt_count_next;
    res.is_attitude    = (held_id_next == attitude_id);
    res.quat_w_bits    = words[0];
    res.quat_x_bits    = words[1];
    res.quat_y_bits    = words[2];
    res.quat_z_bits    = words[3];
    res.roll_bits      = words[4];
    res.pitch_bits     = words[5];
    res.yaw_bits       = words[6];
  end

  slpd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (res),
    .push_ready (buf_ready),
    .result     (result)
  );

endmodule

/* rtl/slpd_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpd_out_buf: two-entry result buffer
// Output register plus a skid entry, so ready toward the framer is registered.
// ----------------------------------------------------------------------------
module slpd_out_buf
  import slpd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  result_t       push_data,
  output logic          push_ready,
  slpd_stream_if.source result
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    pop;

  assign pop            = main_valid && result.ready;
  assign push_ready     = !skid_valid;
  assign result.valid   = main_valid;
  assign result.payload = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule
